// ===== rtl/lat_pkg.sv =====
`default_nettype none

package lat_pkg;

    localparam int MAX_SIDE_DEF = 64;
    localparam int SIDE_W       = 7;
    localparam int ROW_W        = 6;
    localparam int CNT_W        = 4;
    localparam int FUNC_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 8;

    localparam logic [CNT_W-1:0] KEEP_CNT  = CNT_W'(2);
    localparam logic [CNT_W-1:0] BIRTH_CNT = CNT_W'(3);

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 2'd0,
        FN_STEP  = 2'd1,
        FN_READ  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_RD_CUR,
        ST_RD_DN,
        ST_RD_FIN,
        ST_ST_ROW0,
        ST_ST_PRIME,
        ST_ST_ROW
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/life_automaton_torus_step_core.sv =====
// Toroidal B3/S23 life grid, one row of cells per memory word.
// Write: row read, then row write. Read: three row reads (up/center/down), then the
// neighbor count into the result register, which waits while the result is untaken.
// Step: the row memory is swept once, one row written per cycle.
// Unused func codes and out-of-region writes return to idle without a memory access.
// Synchronous active-low reset: all cells dead, rows and cols set to the full side.
`default_nettype none

module life_automaton_torus_step_core #(
    parameter int MAX_SIDE = lat_pkg::MAX_SIDE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tdata: row[5:0], col[11:6], alive_in[12], zero pad [15:13]
    input  wire logic [lat_pkg::IN_DATA_W-1:0] i_s_tdata,
    // tuser: func[1:0]
    input  wire logic [lat_pkg::FUNC_W-1:0]    i_s_tuser,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: alive_out[0], neighbour_count[4:1], zero pad [7:5]
    output logic [lat_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lat_pkg::SIDE_W-1:0]    i_cfg_data
);
    import lat_pkg::*;

    localparam int AW = $clog2(MAX_SIDE);

    t_state r_state, n_state;

    logic [SIDE_W-1:0]   r_rows, r_cols, r_cnt;
    logic [ROW_W-1:0]    r_row, r_col;
    logic                r_alive, r_zero;
    logic [MAX_SIDE-1:0] r_up, r_cur, r_row0;
    logic                r_out_valid, r_out_alive;
    logic [CNT_W-1:0]    r_out_cnt;

    t_func               w_func;
    logic [ROW_W-1:0]    w_in_row, w_in_col;
    logic                w_in_alive, w_inside, w_accept, w_last_row, w_out_load;
    logic [SIDE_W-1:0]   w_clamp;

    logic                w_rd_en, w_wr_en;
    logic [AW-1:0]       w_rd_addr, w_wr_addr;
    logic [MAX_SIDE-1:0] w_wr_data, w_rd_data, w_dn, w_alu_row, w_mask;
    logic                w_alu_alive;
    logic [CNT_W-1:0]    w_alu_cnt;

    assign w_func     = t_func'(i_s_tuser);
    assign w_in_row   = i_s_tdata[ROW_W-1:0];
    assign w_in_col   = i_s_tdata[2*ROW_W-1:ROW_W];
    assign w_in_alive = i_s_tdata[2*ROW_W];
    assign w_inside   = (SIDE_W'(w_in_row) < r_rows) && (SIDE_W'(w_in_col) < r_cols);

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign w_last_row = ((r_cnt + SIDE_W'(1)) == r_rows);
    assign w_dn       = (r_state == ST_ST_ROW && w_last_row) ? r_row0 : w_rd_data;
    assign w_mask     = {{(MAX_SIDE-1){1'b0}}, 1'b1} << r_col[AW-1:0];

    assign w_clamp = (i_cfg_data == '0) ? SIDE_W'(1)
                   : (i_cfg_data > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : i_cfg_data;

    lat_grid_mem #(.MAX_SIDE(MAX_SIDE)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    lat_row_alu #(.MAX_SIDE(MAX_SIDE)) u_alu (
        .i_up    (r_up),
        .i_cur   (r_cur),
        .i_dn    (w_dn),
        .i_cols  (r_cols),
        .i_col   (r_col[AW-1:0]),
        .o_row   (w_alu_row),
        .o_alive (w_alu_alive),
        .o_count (w_alu_cnt)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_func)
                        FN_WRITE: n_state = w_inside ? ST_WR : ST_IDLE;
                        FN_STEP:  n_state = ST_ST_ROW0;
                        FN_READ:  n_state = w_inside ? ST_RD_CUR : ST_RD_FIN;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WR:       n_state = ST_IDLE;
            ST_RD_CUR:   n_state = ST_RD_DN;
            ST_RD_DN:    n_state = ST_RD_FIN;
            ST_RD_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ST_ROW0:  n_state = ST_ST_PRIME;
            ST_ST_PRIME: n_state = ST_ST_ROW;
            ST_ST_ROW: begin
                if (w_last_row) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_rd_en    = 1'b0;
        w_rd_addr  = '0;
        w_wr_en    = 1'b0;
        w_wr_addr  = '0;
        w_wr_data  = w_alu_row;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_func)
                        FN_WRITE: begin
                            w_rd_en   = w_inside;
                            w_rd_addr = w_in_row[AW-1:0];
                        end
                        FN_STEP: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = AW'(r_rows - SIDE_W'(1));
                        end
                        FN_READ: begin
                            w_rd_en   = w_inside;
                            w_rd_addr = (w_in_row == '0) ? AW'(r_rows - SIDE_W'(1))
                                                         : AW'(w_in_row - ROW_W'(1));
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_row[AW-1:0];
                w_wr_data = (w_rd_data & ~w_mask) | (r_alive ? w_mask : '0);
            end
            ST_RD_CUR: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_row[AW-1:0];
            end
            ST_RD_DN: begin
                w_rd_en   = 1'b1;
                w_rd_addr = ((SIDE_W'(r_row) + SIDE_W'(1)) == r_rows) ? '0
                          : AW'(SIDE_W'(r_row) + SIDE_W'(1));
            end
            ST_RD_FIN: begin
                w_out_load = !r_out_valid || i_m_tready;
            end
            ST_ST_ROW0: begin
                w_rd_en   = 1'b1;
                w_rd_addr = '0;
            end
            ST_ST_PRIME: begin
                w_rd_en   = (r_rows > SIDE_W'(1));
                w_rd_addr = AW'(1);
            end
            ST_ST_ROW: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt[AW-1:0];
                w_rd_en   = ((r_cnt + SIDE_W'(2)) < r_rows);
                w_rd_addr = AW'(r_cnt + SIDE_W'(2));
            end
            default: begin
            end
        endcase
    end

    // row window and request payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row   <= w_in_row;
            r_col   <= w_in_col;
            r_alive <= w_in_alive;
        end
        unique case (r_state)
            ST_RD_CUR:  r_up <= w_rd_data;
            ST_RD_DN:   r_cur <= w_rd_data;
            ST_ST_ROW0: r_up <= w_rd_data;
            ST_ST_PRIME: begin
                r_cur  <= w_rd_data;
                r_row0 <= w_rd_data;
            end
            ST_ST_ROW: begin
                r_up  <= r_cur;
                r_cur <= w_dn;
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_alive <= r_zero ? 1'b0 : w_alu_alive;
            r_out_cnt   <= r_zero ? '0 : w_alu_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows      <= SIDE_W'(MAX_SIDE);
            r_cols      <= SIDE_W'(MAX_SIDE);
            r_cnt       <= '0;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_zero <= !w_inside;
            end
            if (r_state == ST_ST_PRIME) begin
                r_cnt <= '0;
            end else if (r_state == ST_ST_ROW) begin
                r_cnt <= r_cnt + SIDE_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ROWS: r_rows <= w_clamp;
                    CFG_COLS: r_cols <= w_clamp;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_DATA_W - CNT_W - 1)'(0), r_out_cnt, r_out_alive};

    a_wr_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (SIDE_W'(w_wr_addr) < r_rows))
        else $error("row write outside active rows");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rd_en && w_wr_en) |-> (w_rd_addr != w_wr_addr))
        else $error("read and write to the same row in one cycle");

    a_side_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rows != '0) && (r_rows <= SIDE_W'(MAX_SIDE))
        && (r_cols != '0) && (r_cols <= SIDE_W'(MAX_SIDE)))
        else $error("grid size out of range");

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten before taken");

endmodule

`default_nettype wire

// ===== rtl/lat_grid_mem.sv =====
`default_nettype none

module lat_grid_mem #(
    parameter int MAX_SIDE = lat_pkg::MAX_SIDE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [$clog2(MAX_SIDE)-1:0] i_rd_addr,
    input  wire logic                        i_wr_en,
    input  wire logic [$clog2(MAX_SIDE)-1:0] i_wr_addr,
    input  wire logic [MAX_SIDE-1:0]         i_wr_data,
    output logic      [MAX_SIDE-1:0]         o_rd_data
);
    import lat_pkg::*;

    logic [MAX_SIDE-1:0] r_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] r_rd_q;
    logic [MAX_SIDE-1:0] r_vld;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // row valid bits: an unwritten row reads as all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

`default_nettype wire

// ===== rtl/lat_row_alu.sv =====
`default_nettype none

module lat_row_alu #(
    parameter int MAX_SIDE = lat_pkg::MAX_SIDE_DEF
) (
    input  wire logic [MAX_SIDE-1:0]         i_up,
    input  wire logic [MAX_SIDE-1:0]         i_cur,
    input  wire logic [MAX_SIDE-1:0]         i_dn,
    input  wire logic [lat_pkg::SIDE_W-1:0]  i_cols,
    input  wire logic [$clog2(MAX_SIDE)-1:0] i_col,
    output logic      [MAX_SIDE-1:0]         o_row,
    output logic                             o_alive,
    output logic      [lat_pkg::CNT_W-1:0]   o_count
);
    import lat_pkg::*;

    localparam int AW = $clog2(MAX_SIDE);

    logic [CNT_W-1:0] w_cnt [MAX_SIDE];
    logic [AW-1:0]    w_last;

    assign w_last = AW'(i_cols - SIDE_W'(1));

    for (genvar c = 0; c < MAX_SIDE; c++) begin : g_lane
        logic u_l, u_c, u_r, m_l, m_r, d_l, d_c, d_r;
        logic w_keep;

        assign u_c = i_up[c];
        assign d_c = i_dn[c];

        if (c == 0) begin : g_left_wrap
            assign u_l = i_up[w_last];
            assign m_l = i_cur[w_last];
            assign d_l = i_dn[w_last];
        end else begin : g_left
            assign u_l = i_up[c-1];
            assign m_l = i_cur[c-1];
            assign d_l = i_dn[c-1];
        end

        if (c == MAX_SIDE - 1) begin : g_right_wrap
            assign u_r = i_up[0];
            assign m_r = i_cur[0];
            assign d_r = i_dn[0];
        end else begin : g_right
            logic w_edge;
            assign w_edge = (i_cols == SIDE_W'(c + 1));
            assign u_r    = w_edge ? i_up[0]  : i_up[c+1];
            assign m_r    = w_edge ? i_cur[0] : i_cur[c+1];
            assign d_r    = w_edge ? i_dn[0]  : i_dn[c+1];
        end

        assign w_cnt[c] = CNT_W'(u_l) + CNT_W'(u_c) + CNT_W'(u_r) + CNT_W'(m_l)
                        + CNT_W'(m_r) + CNT_W'(d_l) + CNT_W'(d_c) + CNT_W'(d_r);

        assign w_keep = i_cur[c] ? (w_cnt[c] == KEEP_CNT || w_cnt[c] == BIRTH_CNT)
                                 : (w_cnt[c] == BIRTH_CNT);

        // columns past the active width keep their value
        assign o_row[c] = (SIDE_W'(c) < i_cols) ? w_keep : i_cur[c];
    end

    assign o_alive = i_cur[i_col];
    assign o_count = w_cnt[i_col];

endmodule

`default_nettype wire
